// File: design/loc_pkg.sv
// Shared types and codes for the lock order checker.
`default_nettype none
package loc_pkg;

  localparam int ACTION_W   = 3;
  localparam int FIELD_W    = 16;
  localparam int STATUS_W   = 2;
  localparam int ERROR_W    = 3;
  localparam int COUNT_W    = 32;
  localparam int HELD_OUT_W = 5;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 80;

  localparam logic [ACTION_W-1:0] ACT_LOCK   = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_TRY    = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_UNLOCK = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_SET    = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_CLEAR  = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BUSY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FAIL = 2'd2;

  localparam logic [ERROR_W-1:0] ERR_NONE      = 3'd0;
  localparam logic [ERROR_W-1:0] ERR_RECURSIVE = 3'd1;
  localparam logic [ERROR_W-1:0] ERR_ORDER     = 3'd2;
  localparam logic [ERROR_W-1:0] ERR_UNLOCK    = 3'd3;
  localparam logic [ERROR_W-1:0] ERR_FULL      = 3'd4;

  typedef struct packed {
    logic accept;
    logic scan_start;
    logic read_top;
    logic exec;
    logic load_out;
  } loc_cmd_t;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic                handle_nz;
    logic                enable;
    logic                depth_nz;
    logic                scan_done;
    logic                out_free;
  } loc_stat_t;

endpackage
`default_nettype wire

// File: design/loc_ctrl.sv
// Controller state machine: sequences accept, scan, update and result load.
`default_nettype none
module loc_ctrl (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              in_tvalid,
  output logic             in_tready,
  input  wire loc_pkg::loc_stat_t stat,
  output loc_pkg::loc_cmd_t  cmd
);
  import loc_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DISP = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_EXEC = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic       is_acq;

  assign in_tready = (state_r == S_IDLE);
  assign is_acq    = (stat.action == ACT_LOCK) || (stat.action == ACT_TRY);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_DISP;
        end
      end
      S_DISP: begin
        priority if (stat.handle_nz &&
                     ((is_acq && stat.enable) || stat.action == ACT_SET)) begin
          cmd.scan_start = 1'b1;
          state_nxt      = S_SCAN;
        end else if (stat.handle_nz && stat.enable && stat.depth_nz &&
                     stat.action == ACT_UNLOCK) begin
          cmd.read_top = 1'b1;
          state_nxt    = S_EXEC;
        end else begin
          state_nxt = S_EXEC;
        end
      end
      S_SCAN: begin
        if (stat.scan_done) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

endmodule
`default_nettype wire

// File: design/loc_datapath.sv
// Datapath: order table and held stack memories, scan engine, counters, result register.
`default_nettype none
module loc_datapath #(
  parameter int TABLE_DEPTH = 64,
  parameter int HELD_DEPTH  = 16,
  parameter int HANDLE_BITS = 16
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire loc_pkg::loc_cmd_t              cmd,
  output loc_pkg::loc_stat_t                  stat,
  input  wire [loc_pkg::IN_DATA_W-1:0]        in_tdata,
  input  wire [loc_pkg::ACTION_W-1:0]         in_tuser,
  input  wire                                 cfg_valid,
  input  wire                                 cfg_data,
  output logic                                out_tvalid,
  input  wire                                 out_tready,
  output logic [loc_pkg::OUT_DATA_W-1:0]      out_tdata
);
  import loc_pkg::*;

  localparam int HW  = (HANDLE_BITS < FIELD_W) ? HANDLE_BITS : FIELD_W;
  localparam int TCW = $clog2(TABLE_DEPTH + 1);
  localparam int TAW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int SCW = $clog2(HELD_DEPTH + 1);
  localparam int SAW = (HELD_DEPTH > 1) ? $clog2(HELD_DEPTH) : 1;

  // Latched item
  logic [ACTION_W-1:0]       act_r;
  logic [HW-1:0]             h_r;
  logic signed [FIELD_W-1:0] ord_r;
  logic                      busy_r;

  // Architectural state
  logic                en_r;
  logic [TCW-1:0]      used_r, used_nxt;
  logic [SCW-1:0]      depth_r, depth_nxt;
  logic [ERROR_W-1:0]  err_r, err_nxt;
  logic [COUNT_W-1:0]  acq_r, acq_nxt, viol_r, viol_nxt;
  logic [STATUS_W-1:0] status_r, status_nxt;

  // Memories
  logic [HW-1:0]             tbl_h   [TABLE_DEPTH];
  logic signed [FIELD_W-1:0] tbl_id  [TABLE_DEPTH];
  logic [HW-1:0]             stk_h   [HELD_DEPTH];
  logic signed [FIELD_W-1:0] stk_ord [HELD_DEPTH];
  logic [HW-1:0]             tbl_rd_h_r, stk_rd_h_r;
  logic signed [FIELD_W-1:0] tbl_rd_id_r, stk_rd_ord_r;
  logic [TAW-1:0]            tbl_raddr, tbl_waddr;
  logic [SAW-1:0]            stk_raddr;
  logic                      tbl_we, stk_we;
  logic signed [FIELD_W-1:0] oid;

  // Scan engine
  logic                      run_r;
  logic [TCW-1:0]            t_idx_r;
  logic [TAW-1:0]            t_pidx_r;
  logic                      t_pend_r, t_iss;
  logic                      found_r;
  logic [TAW-1:0]            found_idx_r;
  logic signed [FIELD_W-1:0] found_id_r;
  logic [SCW-1:0]            s_idx_r;
  logic                      s_pend_r, s_iss;
  logic                      held_r;
  logic signed [FIELD_W-1:0] max_r;
  logic                      scan_end;

  // Result register
  logic                      out_valid_r;
  logic [OUT_DATA_W-1:0]     out_data_r;

  assign t_iss    = run_r && (t_idx_r < used_r);
  assign s_iss    = run_r && (s_idx_r < depth_r);
  assign scan_end = !t_iss && !t_pend_r && !s_iss && !s_pend_r;

  assign tbl_raddr = t_idx_r[TAW-1:0];
  assign stk_raddr = cmd.read_top ? SAW'(depth_r - 1'b1) : s_idx_r[SAW-1:0];
  assign oid       = found_r ? found_id_r : '0;

  assign stat.action    = act_r;
  assign stat.handle_nz = (h_r != '0);
  assign stat.enable    = en_r;
  assign stat.depth_nz  = (depth_r != '0);
  assign stat.scan_done = run_r && scan_end;
  assign stat.out_free  = !out_valid_r || out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Update decision for one item
  always_comb begin
    status_nxt = status_r;
    err_nxt    = err_r;
    acq_nxt    = acq_r;
    viol_nxt   = viol_r;
    used_nxt   = used_r;
    depth_nxt  = depth_r;
    tbl_we     = 1'b0;
    stk_we     = 1'b0;
    tbl_waddr  = found_r ? found_idx_r : used_r[TAW-1:0];
    if (cmd.exec) begin
      status_nxt = ST_OK;
      unique case (act_r)
        ACT_LOCK, ACT_TRY: begin
          priority if (h_r == '0) begin
            status_nxt = ST_FAIL;
          end else if (!en_r) begin
            if (act_r == ACT_TRY && busy_r) status_nxt = ST_BUSY;
          end else if (held_r) begin
            err_nxt    = ERR_RECURSIVE;
            status_nxt = ST_FAIL;
          end else if (oid != 16'sd0 && max_r > 16'sd0 && oid <= max_r) begin
            err_nxt    = ERR_ORDER;
            viol_nxt   = viol_r + 1'b1;
            status_nxt = ST_FAIL;
          end else if (act_r == ACT_TRY && busy_r) begin
            status_nxt = ST_BUSY;
          end else if (depth_r == SCW'(HELD_DEPTH)) begin
            err_nxt = ERR_FULL;
          end else begin
            stk_we    = 1'b1;
            depth_nxt = depth_r + 1'b1;
            acq_nxt   = acq_r + 1'b1;
            err_nxt   = ERR_NONE;
          end
        end
        ACT_UNLOCK: begin
          priority if (h_r == '0) begin
            status_nxt = ST_FAIL;
          end else if (!en_r) begin
            status_nxt = ST_OK;
          end else if (depth_r == '0 || stk_rd_h_r != h_r) begin
            err_nxt    = ERR_UNLOCK;
            status_nxt = ST_FAIL;
          end else begin
            depth_nxt = depth_r - 1'b1;
            err_nxt   = ERR_NONE;
          end
        end
        ACT_SET: begin
          priority if (h_r == '0) begin
            status_nxt = ST_FAIL;
          end else if (found_r) begin
            tbl_we = 1'b1;
          end else if (used_r == TCW'(TABLE_DEPTH)) begin
            err_nxt    = ERR_FULL;
            status_nxt = ST_FAIL;
          end else begin
            tbl_we   = 1'b1;
            used_nxt = used_r + 1'b1;
          end
        end
        ACT_CLEAR: begin
          err_nxt   = ERR_NONE;
          acq_nxt   = '0;
          viol_nxt  = '0;
          used_nxt  = '0;
          depth_nxt = '0;
        end
        default: status_nxt = ST_FAIL;
      endcase
    end
  end

  // Memories: one write and one registered read each
  always_ff @(posedge clk) begin
    if (tbl_we) begin
      tbl_h[tbl_waddr]  <= h_r;
      tbl_id[tbl_waddr] <= ord_r;
    end
    tbl_rd_h_r  <= tbl_h[tbl_raddr];
    tbl_rd_id_r <= tbl_id[tbl_raddr];
  end

  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk_h[depth_r[SAW-1:0]]   <= h_r;
      stk_ord[depth_r[SAW-1:0]] <= oid;
    end
    stk_rd_h_r   <= stk_h[stk_raddr];
    stk_rd_ord_r <= stk_ord[stk_raddr];
  end

  // Item latch and scan payload
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      act_r  <= in_tuser;
      h_r    <= in_tdata[HW-1:0];
      ord_r  <= in_tdata[2*FIELD_W-1:FIELD_W];
      busy_r <= in_tdata[2*FIELD_W];
    end
    if (cmd.scan_start) begin
      t_idx_r <= '0;
      s_idx_r <= '0;
      found_r <= 1'b0;
      held_r  <= 1'b0;
      max_r   <= '0;
    end else begin
      if (t_iss) t_idx_r <= t_idx_r + 1'b1;
      if (s_iss) s_idx_r <= s_idx_r + 1'b1;
      t_pidx_r <= t_idx_r[TAW-1:0];
      // keep the first table match only
      if (t_pend_r && !found_r && tbl_rd_h_r == h_r) begin
        found_r     <= 1'b1;
        found_idx_r <= t_pidx_r;
        found_id_r  <= tbl_rd_id_r;
      end
      if (s_pend_r) begin
        if (stk_rd_h_r == h_r) held_r <= 1'b1;
        if (stk_rd_ord_r > max_r) max_r <= stk_rd_ord_r;
      end
    end
    if (cmd.load_out) begin
      out_data_r <= {6'd0, HELD_OUT_W'(depth_r), viol_r, acq_r, err_r, status_r};
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r        <= 1'b0;
      used_r      <= '0;
      depth_r     <= '0;
      err_r       <= ERR_NONE;
      acq_r       <= '0;
      viol_r      <= '0;
      status_r    <= ST_OK;
      run_r       <= 1'b0;
      t_pend_r    <= 1'b0;
      s_pend_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) en_r <= cfg_data;
      used_r   <= used_nxt;
      depth_r  <= depth_nxt;
      err_r    <= err_nxt;
      acq_r    <= acq_nxt;
      viol_r   <= viol_nxt;
      status_r <= status_nxt;
      if (cmd.scan_start) begin
        run_r    <= 1'b1;
        t_pend_r <= 1'b0;
        s_pend_r <= 1'b0;
      end else begin
        if (run_r && scan_end) run_r <= 1'b0;
        t_pend_r <= t_iss;
        s_pend_r <= s_iss;
      end
      if (cmd.load_out)    out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

endmodule
`default_nettype wire

// File: design/lock_order_checker_unit.sv
// Top level of the lock order checker: controller plus datapath.
// Set order, and lock or try lock with checking on and a nonzero handle, scan the order table
//   and the held stack before the update; other items go straight to the update.
// Throughput: one item at a time; the longer of the table and held stack scans sets the rate.
// A finished result waits in the output register while the next item is taken.
// Reset (rst_n low, synchronous) clears checking enable, counters, table fill and stack depth.
`default_nettype none
module lock_order_checker_unit #(
  parameter int TABLE_DEPTH = 64,
  parameter int HELD_DEPTH  = 16,
  parameter int HANDLE_BITS = 16
) (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire                             in_tvalid,
  output logic                            in_tready,
  // lock_handle[15:0], order_value[31:16], lock_busy[32], zero fill
  input  wire [loc_pkg::IN_DATA_W-1:0]    in_tdata,
  // action[2:0]
  input  wire [loc_pkg::ACTION_W-1:0]     in_tuser,
  input  wire                             cfg_valid,
  output logic                            cfg_ready,
  input  wire                             cfg_data,
  output logic                            out_tvalid,
  input  wire                             out_tready,
  // status[1:0], last_error[4:2], acquire_count[36:5], violation_count[68:37],
  // held_count[73:69], zero fill
  output logic [loc_pkg::OUT_DATA_W-1:0]  out_tdata
);
  import loc_pkg::*;

  loc_cmd_t  cmd;
  loc_stat_t stat;

  assign cfg_ready = 1'b1;

  loc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  loc_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .HELD_DEPTH  (HELD_DEPTH),
    .HANDLE_BITS (HANDLE_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
`default_nettype wire

// File: design/loc_checker.sv
// Port-level checks for the lock order checker, bound to the top level.
`default_nettype none
module loc_checker #(
  parameter int HELD_DEPTH = 16
) (
  input wire                            clk,
  input wire                            rst_n,
  input wire                            in_tvalid,
  input wire                            in_tready,
  input wire                            out_tvalid,
  input wire                            out_tready,
  input wire [loc_pkg::OUT_DATA_W-1:0]  out_tdata
);
  import loc_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second item taken before the first finished");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[1:0] != 2'd3)
    else $error("undefined status code");

  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[73:69] <= HELD_OUT_W'(HELD_DEPTH))
    else $error("held count beyond stack depth");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

endmodule

bind lock_order_checker_unit loc_checker #(.HELD_DEPTH(HELD_DEPTH)) u_loc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
`default_nettype wire
